### rtl/csa_pkg.sv
package csa_pkg;

	localparam int DEF_SLOTS = 128;

	// field widths fixed by the item formats
	localparam int SIZE_W  = 8;
	localparam int BASE_W  = 7;
	localparam int HOLES_W = 7;
	localparam int USED_W  = 8;
	localparam int RES_W   = 8;
	localparam int POL_W   = 2;

	localparam logic [RES_W-1:0] RES_MAX = 8'd255;

	// placement policies
	localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POL_W-1:0] POL_WORST = 2'd2;
	localparam logic [POL_W-1:0] POL_NEXT  = 2'd3;

	// request kinds
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] block_size;
	} req_t;

	typedef struct packed {
		logic               granted;
		logic [BASE_W-1:0]  base_slot;
		logic [HOLES_W-1:0] free_holes;
		logic [USED_W-1:0]  used_slots;
		logic [RES_W-1:0]   resident_blocks;
	} rsp_t;

	// sequencer to search unit
	typedef struct packed {
		logic clear;   // new item, drop previous search results
		logic step;    // one real slot presented
		logic last;    // closing step past the last slot
	} fit_ctl_t;

endpackage

### rtl/csa_stream_if.sv
interface csa_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/csa_ring.sv
// Occupancy bitmap as a rotating shift ring; slot under the head is bit 0.
module csa_ring #(
	parameter int SLOTS = csa_pkg::DEF_SLOTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  logic wr_bit,
	output logic head
);

	logic [SLOTS-1:0] occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (shift) begin
			occ_q <= {wr_bit, occ_q[SLOTS-1:1]};
		end
	end

	assign head = occ_q[0];

endmodule

### rtl/csa_fit.sv
// Run tracker: sees one slot per step and keeps the candidates of every policy.
module csa_fit #(
	parameter int SLOTS = csa_pkg::DEF_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csa_pkg::fit_ctl_t             ctl,
	input  logic [$clog2(SLOTS+1)-1:0]    idx,
	input  logic                          occ,
	input  logic [csa_pkg::SIZE_W-1:0]    size,
	input  logic [$clog2(SLOTS)-1:0]      ns_start,
	input  logic [csa_pkg::POL_W-1:0]     policy,
	input  logic                          mode,
	output logic                          found,
	output logic [$clog2(SLOTS)-1:0]      base
);

	localparam int IW = $clog2(SLOTS+1);
	localparam int AW = $clog2(SLOTS);
	localparam int CW = (IW > csa_pkg::SIZE_W) ? IW : csa_pkg::SIZE_W;

	logic [CW-1:0] run_q, runn_q, rk_len_q;
	logic          ff_found_q, nf_found_q, of_found_q, rk_found_q;
	logic [AW-1:0] ff_base_q, nf_base_q, of_base_q, rk_base_q;

	logic [CW-1:0] size_w, idx_w, run_inc, runn_inc, fit_base, rk_base;
	logic          free, in_zone, ff_hit, nf_hit, rk_close, rk_take;

	always_comb begin
		size_w   = CW'(size);
		idx_w    = CW'(idx);
		run_inc  = run_q + CW'(1);
		runn_inc = runn_q + CW'(1);
		free     = !occ;
		in_zone  = idx_w >= CW'(ns_start);
		fit_base = idx_w + CW'(1) - size_w;
		rk_base  = idx_w - run_q;
		ff_hit   = ctl.step && free && !ff_found_q && (run_inc == size_w);
		nf_hit   = ctl.step && free && in_zone && !nf_found_q && (runn_inc == size_w);
		// a run closes on an occupied slot or past the end
		rk_close = (ctl.last || (ctl.step && occ)) && (run_q >= size_w) && (run_q != '0);
		if (policy == csa_pkg::POL_BEST) begin
			rk_take = !rk_found_q || (run_q < rk_len_q);
		end else begin
			rk_take = !rk_found_q || (run_q > rk_len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			runn_q     <= '0;
			rk_len_q   <= '0;
			ff_found_q <= 1'b0;
			nf_found_q <= 1'b0;
			of_found_q <= 1'b0;
			rk_found_q <= 1'b0;
		end else if (ctl.clear) begin
			run_q      <= '0;
			runn_q     <= '0;
			rk_len_q   <= '0;
			ff_found_q <= 1'b0;
			nf_found_q <= 1'b0;
			of_found_q <= 1'b0;
			rk_found_q <= 1'b0;
		end else if (ctl.step || ctl.last) begin
			run_q  <= (ctl.step && free) ? run_inc : '0;
			runn_q <= (ctl.step && free && in_zone) ? runn_inc : '0;
			if (ff_hit) ff_found_q <= 1'b1;
			if (nf_hit) nf_found_q <= 1'b1;
			if (ctl.step && occ) of_found_q <= 1'b1;
			if (rk_close && rk_take) begin
				rk_found_q <= 1'b1;
				rk_len_q   <= run_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ff_hit) ff_base_q <= AW'(fit_base);
		if (nf_hit) nf_base_q <= AW'(fit_base);
		if (ctl.step && occ && !of_found_q) of_base_q <= AW'(idx);
		if (!ctl.clear && rk_close && rk_take) rk_base_q <= AW'(rk_base);
	end

	always_comb begin
		found = ff_found_q;
		base  = ff_base_q;
		if (mode == csa_pkg::MODE_FREE) begin
			found = of_found_q;
			base  = of_base_q;
		end else begin
			case (policy)
				csa_pkg::POL_FIRST: begin
					found = ff_found_q;
					base  = ff_base_q;
				end
				csa_pkg::POL_BEST, csa_pkg::POL_WORST: begin
					found = rk_found_q;
					base  = rk_base_q;
				end
				csa_pkg::POL_NEXT: begin
					found = nf_found_q || ff_found_q;
					base  = nf_found_q ? nf_base_q : ff_base_q;
				end
				default: begin
					found = ff_found_q;
					base  = ff_base_q;
				end
			endcase
		end
	end

endmodule

### rtl/contiguous_slot_allocator_unit.sv
// Contiguous slot allocator over a bitmap of SLOTS slots.
// req channel (sink): mode (allocate / release) and block_size. rsp channel
// (source): granted, base_slot, free_holes, used_slots, resident_blocks; one
// rsp item per req item, in order. cfg_we/cfg_wdata write fit_policy
// (first, best, worst, next fit); write it only while the block is idle.
// The bitmap is a rotating shift ring read one slot per cycle at its head.
// Each item makes two trips round the ring: a search pass over every slot
// plus a closing step past the last one (it closes the last free run for
// best/worst fit) and a commit pass that marks or clears the run and counts
// the holes and used slots on the new contents. The final state then moves
// the result into the output register. One item is worked on at a time: a
// new req item is taken only in the idle state.
// A finished result waits in the output register, so the next req item is
// taken while rsp is stalled; a second result waits in the final state until
// the register frees up, and no further item is taken meanwhile.
// Reset (arst_n low) frees every slot at once, clears counts, next fit start
// and fit_policy (first fit); no clearing pass is needed.
module contiguous_slot_allocator_unit #(
	parameter int SLOTS = csa_pkg::DEF_SLOTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [csa_pkg::POL_W-1:0] cfg_wdata,
	csa_stream_if.sink                req,
	csa_stream_if.source              rsp
);

	localparam int IW = $clog2(SLOTS+1);
	localparam int AW = $clog2(SLOTS);
	localparam int SW = ((IW > csa_pkg::SIZE_W) ? IW : csa_pkg::SIZE_W) + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT,
		S_FINISH
	} state_t;

	state_t                          state_q;
	logic [IW-1:0]                   idx_q;
	logic                            mode_q;
	logic [csa_pkg::SIZE_W-1:0]      size_q;
	logic [csa_pkg::SIZE_W-1:0]      rem_q;     // slots still to mark or clear
	logic [AW-1:0]                   ns_q;      // next fit start
	logic [IW-1:0]                   used_q;
	logic [IW-1:0]                   holes_q;
	logic                            prev_q;    // new value of the previous slot
	logic [csa_pkg::RES_W-1:0]       res_q;
	logic [csa_pkg::POL_W-1:0]       pol_q;
	logic                            rsp_valid_q;
	csa_pkg::rsp_t                   rsp_q;

	logic                            accept, at_end, last_slot, out_free;
	logic                            head, shift, wr_bit, new_bit, hit, grant;
	logic                            ns_move;
	logic [AW-1:0]                   ns_eff, fit_base, slot;
	logic                            fit_found;
	csa_pkg::fit_ctl_t               fit_ctl;

	assign req.ready   = (state_q == S_IDLE);
	assign accept      = req.valid && req.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_comb begin
		at_end    = (idx_q == IW'(SLOTS));
		last_slot = (idx_q == IW'(SLOTS - 1));
		out_free  = !rsp_valid_q || rsp.ready;
		slot      = idx_q[AW-1:0];
		grant     = (size_q != '0) && fit_found;
		hit       = (state_q == S_COMMIT) && grant && (slot >= fit_base) && (rem_q != '0);
		new_bit   = hit ? (mode_q == csa_pkg::MODE_ALLOC) : head;
		shift     = ((state_q == S_SCAN) && !at_end) || (state_q == S_COMMIT);
		wr_bit    = (state_q == S_COMMIT) ? new_bit : head;
		// next fit wraps to slot 0 when the block would run past the end
		ns_eff    = ((SW'(ns_q) + SW'(req.payload.block_size)) > SW'(SLOTS)) ? '0 : ns_q;
		ns_move   = (req.payload.mode == csa_pkg::MODE_ALLOC) &&
		            (req.payload.block_size != '0) && (pol_q == csa_pkg::POL_NEXT);
		fit_ctl.clear = accept;
		fit_ctl.step  = (state_q == S_SCAN) && !at_end;
		fit_ctl.last  = (state_q == S_SCAN) && at_end;
	end

	csa_ring #(
		.SLOTS (SLOTS)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift),
		.wr_bit (wr_bit),
		.head   (head)
	);

	csa_fit #(
		.SLOTS (SLOTS)
	) u_fit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fit_ctl),
		.idx      (idx_q),
		.occ      (head),
		.size     (size_q),
		.ns_start (ns_q),
		.policy   (pol_q),
		.mode     (mode_q),
		.found    (fit_found),
		.base     (fit_base)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			mode_q      <= csa_pkg::MODE_ALLOC;
			size_q      <= '0;
			rem_q       <= '0;
			ns_q        <= '0;
			used_q      <= '0;
			holes_q     <= '0;
			prev_q      <= 1'b0;
			res_q       <= '0;
			pol_q       <= csa_pkg::POL_FIRST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) pol_q <= cfg_wdata;
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= req.payload.mode;
						size_q  <= req.payload.block_size;
						rem_q   <= req.payload.block_size;
						idx_q   <= '0;
						holes_q <= '0;
						prev_q  <= 1'b0;
						if (ns_move) ns_q <= ns_eff;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (at_end) begin
						idx_q   <= '0;
						state_q <= S_COMMIT;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_COMMIT: begin
					if (hit) begin
						rem_q <= rem_q - csa_pkg::SIZE_W'(1);
						if (head != new_bit) begin
							used_q <= new_bit ? used_q + IW'(1) : used_q - IW'(1);
						end
					end
					// a hole starts at a free slot that is slot 0 or follows an occupied one
					if (!new_bit && ((idx_q == '0) || prev_q)) holes_q <= holes_q + IW'(1);
					prev_q <= new_bit;
					idx_q  <= idx_q + IW'(1);
					if (last_slot) begin
						if (grant) begin
							if (mode_q == csa_pkg::MODE_ALLOC) begin
								if (res_q != csa_pkg::RES_MAX) res_q <= res_q + csa_pkg::RES_W'(1);
								if (pol_q == csa_pkg::POL_NEXT) ns_q <= fit_base;
							end else if (res_q != '0) begin
								res_q <= res_q - csa_pkg::RES_W'(1);
							end
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			rsp_q.granted         <= grant;
			rsp_q.base_slot       <= grant ? csa_pkg::BASE_W'(fit_base) : '0;
			rsp_q.free_holes      <= csa_pkg::HOLES_W'(holes_q);
			rsp_q.used_slots      <= csa_pkg::USED_W'(used_q);
			rsp_q.resident_blocks <= res_q;
		end
	end

	// occupied count never exceeds the bitmap
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= IW'(SLOTS))
		else $error("used slot count beyond bitmap size");

	// remaining run length only shrinks during the commit pass
	a_rem_down: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |=> (state_q != S_COMMIT) || (rem_q <= $past(rem_q)))
		else $error("commit run counter grew");

	// a result is only loaded out of the final state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result raised outside final state");

	// the commit pass starts at slot 0 when the search pass ends
	a_pass_start: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && at_end) |=> (idx_q == '0) && (state_q == S_COMMIT))
		else $error("commit pass misaligned with ring");

	// a full result register is never overwritten while stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> rsp_valid_q && $stable(rsp_q))
		else $error("stalled result overwritten");

endmodule
